@@ rtl/core/wbss_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wbss_pkg: shared definitions for the wildcard byte signature scanner
// Field widths, register indexes and parameter defaults used by the
// channel interfaces, the scanner core and its checker.
// ----------------------------------------------------------------------------
package wbss_pkg;

   // parameter defaults
   localparam int MAX_PATTERN_DEF   = 32;
   localparam int POSITION_BITS_DEF = 32;

   // fixed field widths
   localparam int DATA_W     = 8;
   localparam int LEN_W      = 6;
   localparam int MASK_W     = 32;
   localparam int OFFSET_W   = 32;
   localparam int PAT_WORD_W = 64;
   localparam int PAT_WORDS  = 4;
   localparam int PAT_CAP    = PAT_WORDS * (PAT_WORD_W / DATA_W);

   // configuration port
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 64;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_PATTERN_0  = 3'd0,
      CSR_PATTERN_1  = 3'd1,
      CSR_PATTERN_2  = 3'd2,
      CSR_PATTERN_3  = 3'd3,
      CSR_WILDCARD   = 3'd4,
      CSR_LENGTH     = 3'd5
   } csr_index_type;

endpackage

@@ rtl/core/wbss_channels.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wbss_channels: request and response channels of the scanner
// Valid/ready channels; a transfer happens on a clock edge with both high.
// ----------------------------------------------------------------------------
interface wbss_req_if;
   logic                        valid;
   logic                        ready;
   logic [wbss_pkg::DATA_W-1:0] data_byte;
   logic                        range_start;
   logic                        scan_end;

   modport source (output valid, data_byte, range_start, scan_end, input ready);
   modport sink   (input valid, data_byte, range_start, scan_end, output ready);
endinterface

interface wbss_rsp_if;
   logic                          valid;
   logic                          ready;
   logic                          found;
   logic [wbss_pkg::OFFSET_W-1:0] match_offset;
   logic                          unique_res;

   modport source (output valid, found, match_offset, unique_res, input ready);
   modport sink   (input valid, found, match_offset, unique_res, output ready);
endinterface

@@ rtl/core/wildcard_byte_signature_scanner.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wildcard_byte_signature_scanner: masked byte pattern search over a stream
// Slides a window over the incoming bytes, compares it against a pattern
// with per-byte wildcards, and reports the first match offset and whether
// the match was unique when the scan ends.
// ----------------------------------------------------------------------------
//  channel | direction | payload                              | handshake
//  --------+-----------+--------------------------------------+------------
//  req_bus | in        | data_byte, range_start, scan_end     | valid/ready
//  rsp_bus | out       | found, match_offset, unique_res      | valid/ready
//  csr_*   | in        | csr_index, csr_write_data            | write enable
//
//  One byte per cycle. A request is captured in an input register; when it
//  advances it is shifted into the window and the parallel masked compare
//  runs, and for a request carrying scan_end the response register loads on
//  that same edge. Reset is synchronous and clears the configuration,
//  control, count, position and match state; window and data registers are
//  qualified by them. A waiting response stalls the input only when a second
//  scan end reaches the compare stage; other bytes keep flowing.
// ----------------------------------------------------------------------------
module wildcard_byte_signature_scanner #(
   parameter int MAX_PATTERN   = wbss_pkg::MAX_PATTERN_DEF,
   parameter int POSITION_BITS = wbss_pkg::POSITION_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   wbss_req_if.sink                        req_bus,
   wbss_rsp_if.source                      rsp_bus,
   input  logic                            csr_write_en,
   input  logic [wbss_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [wbss_pkg::CSR_DATA_W-1:0] csr_write_data
);

   localparam int WIN_IDX_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
   localparam int CNT_W     = $clog2(MAX_PATTERN + 1);
   localparam logic [CNT_W-1:0]         CNT_TOP = CNT_W'(MAX_PATTERN);
   localparam logic [POSITION_BITS-1:0] POS_TOP = '1;

   // configuration registers
   logic [wbss_pkg::PAT_WORD_W-1:0] pat_ff [wbss_pkg::PAT_WORDS];
   logic [wbss_pkg::MASK_W-1:0]     mask_ff;
   logic [wbss_pkg::LEN_W-1:0]      len_ff;

   // input register
   logic                        s0_valid_ff;
   logic [wbss_pkg::DATA_W-1:0] s0_byte_ff;
   logic                        s0_start_ff;
   logic                        s0_end_ff;

   // scan state
   logic [wbss_pkg::DATA_W-1:0] window_ff [MAX_PATTERN];
   logic [CNT_W-1:0]            count_ff;
   logic [POSITION_BITS-1:0]    pos_ff;
   logic                        first_seen_ff;
   logic [POSITION_BITS-1:0]    first_off_ff;
   logic                        second_seen_ff;

   // output register
   logic                          rsp_valid_ff;
   logic                          rsp_found_ff;
   logic [wbss_pkg::OFFSET_W-1:0] rsp_off_ff;
   logic                          rsp_unique_ff;

   // next values
   logic [wbss_pkg::DATA_W-1:0] window_in [MAX_PATTERN];
   logic [CNT_W-1:0]            count_in;
   logic                        match;
   logic [POSITION_BITS-1:0]    start_at;
   logic                        first_seen_in;
   logic [POSITION_BITS-1:0]    first_off_in;
   logic                        second_seen_in;
   logic                        advance;
   logic                        req_take;

   // pipeline control: only a scan end needs a free output register
   assign advance  = s0_valid_ff && (!s0_end_ff || !rsp_valid_ff || rsp_bus.ready);
   assign req_bus.ready = !s0_valid_ff || advance;
   assign req_take = req_bus.valid && req_bus.ready;

   // window shift and range byte count
   always_comb begin
      logic [CNT_W-1:0] base;
      base = s0_start_ff ? '0 : count_ff;
      count_in = (base == CNT_TOP) ? base : base + CNT_W'(1);
      window_in[0] = s0_byte_ff;
      for (int i = 1; i < MAX_PATTERN; i++) begin
         window_in[i] = window_ff[i-1];
      end
   end

   // parallel masked compare; pattern byte j lines up with window slot len-1-j
   always_comb begin
      logic [wbss_pkg::DATA_W-1:0] pat_byte;
      logic [WIN_IDX_W-1:0]        sel;
      logic                        all_ok;
      logic                        len_ok;
      all_ok = 1'b1;
      for (int j = 0; j < MAX_PATTERN; j++) begin
         pat_byte = pat_ff[j >> 3][8*(j & 7) +: 8];
         sel      = WIN_IDX_W'(int'(len_ff) - 1 - j);
         if ((j < int'(len_ff)) && !mask_ff[j] && (window_in[sel] != pat_byte)) begin
            all_ok = 1'b0;
         end
      end
      len_ok = (len_ff != '0) && (int'(len_ff) <= MAX_PATTERN)
               && (int'(count_in) >= int'(len_ff));
      match = len_ok && all_ok;
   end

   // match start offset, clamped at zero
   always_comb begin
      logic [POSITION_BITS-1:0] back;
      back = POSITION_BITS'(len_ff) - POSITION_BITS'(1);
      start_at = (pos_ff >= back) ? (pos_ff - back) : '0;
   end

   // first / second match tracking
   always_comb begin
      first_seen_in  = first_seen_ff;
      first_off_in   = first_off_ff;
      second_seen_in = second_seen_ff;
      if (match) begin
         if (!first_seen_ff) begin
            first_seen_in = 1'b1;
            first_off_in  = start_at;
         end else begin
            second_seen_in = 1'b1;
         end
      end
   end

   // registers
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int w = 0; w < wbss_pkg::PAT_WORDS; w++) begin
            pat_ff[w] <= '0;
         end
         mask_ff        <= '0;
         len_ff         <= '0;
         s0_valid_ff    <= 1'b0;
         count_ff       <= '0;
         pos_ff         <= '0;
         first_seen_ff  <= 1'b0;
         first_off_ff   <= '0;
         second_seen_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         // register writes
         if (csr_write_en) begin
            unique case (csr_index)
               wbss_pkg::CSR_PATTERN_0: pat_ff[0] <= csr_write_data;
               wbss_pkg::CSR_PATTERN_1: pat_ff[1] <= csr_write_data;
               wbss_pkg::CSR_PATTERN_2: pat_ff[2] <= csr_write_data;
               wbss_pkg::CSR_PATTERN_3: pat_ff[3] <= csr_write_data;
               wbss_pkg::CSR_WILDCARD:  mask_ff <= csr_write_data[wbss_pkg::MASK_W-1:0];
               wbss_pkg::CSR_LENGTH:    len_ff  <= csr_write_data[wbss_pkg::LEN_W-1:0];
               default: ;
            endcase
         end

         // input register
         if (req_take) begin
            s0_valid_ff <= 1'b1;
         end else if (advance) begin
            s0_valid_ff <= 1'b0;
         end

         // scan state; a scan end clears the count, position and match state
         if (advance) begin
            if (s0_end_ff) begin
               count_ff       <= '0;
               pos_ff         <= '0;
               first_seen_ff  <= 1'b0;
               first_off_ff   <= '0;
               second_seen_ff <= 1'b0;
            end else begin
               count_ff       <= count_in;
               pos_ff         <= (pos_ff == POS_TOP) ? pos_ff
                                                     : pos_ff + POSITION_BITS'(1);
               first_seen_ff  <= first_seen_in;
               first_off_ff   <= first_off_in;
               second_seen_ff <= second_seen_in;
            end
         end

         // output register
         if (advance && s0_end_ff) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end

      // payload registers
      if (req_take) begin
         s0_byte_ff  <= req_bus.data_byte;
         s0_start_ff <= req_bus.range_start;
         s0_end_ff   <= req_bus.scan_end;
      end
      if (advance) begin
         for (int i = 0; i < MAX_PATTERN; i++) begin
            window_ff[i] <= window_in[i];
         end
      end
      if (advance && s0_end_ff) begin
         rsp_found_ff  <= first_seen_in;
         rsp_off_ff    <= first_seen_in ? wbss_pkg::OFFSET_W'(first_off_in) : '0;
         rsp_unique_ff <= !second_seen_in;
      end
   end

   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.found        = rsp_found_ff;
   assign rsp_bus.match_offset = rsp_off_ff;
   assign rsp_bus.unique_res   = rsp_unique_ff;

endmodule

@@ rtl/core/wbss_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wbss_checker: port-level checks for the wildcard byte signature scanner
// Watches the response channel for consistent results and a preceding request.
// ----------------------------------------------------------------------------
module wbss_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic                          rsp_found,
   input logic [wbss_pkg::OFFSET_W-1:0] rsp_match_offset,
   input logic                          rsp_unique_res
);

   // a pending response is not withdrawn
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   // no match means a zero offset
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_found |-> rsp_match_offset == '0)
      else $error("offset set without a match");

   // no match means nothing ambiguous either
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_found |-> rsp_unique_res)
      else $error("ambiguous flag without a match");

   // a new response needs a request taken earlier, or a response already pending
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready, 2) || $past(rsp_valid))
      else $error("response without a preceding request");

endmodule

bind wildcard_byte_signature_scanner wbss_checker u_wbss_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_bus.valid),
   .req_ready        (req_bus.ready),
   .rsp_valid        (rsp_bus.valid),
   .rsp_ready        (rsp_bus.ready),
   .rsp_found        (rsp_bus.found),
   .rsp_match_offset (rsp_bus.match_offset),
   .rsp_unique_res   (rsp_bus.unique_res)
);

@@ bench/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the wildcard byte signature scanner
// Streams memory bytes, split into ranges and scans, through the request
// channel. An in-bench model of the sliding window and the masked compare
// predicts each end-of-scan verdict, and every response is checked field by
// field. Random request gaps and response stalls run through most phases.
// ----------------------------------------------------------------------------
module tb;

   localparam int DATA_W     = wbss_pkg::DATA_W;
   localparam int LEN_W      = wbss_pkg::LEN_W;
   localparam int MASK_W     = wbss_pkg::MASK_W;
   localparam int OFFSET_W   = wbss_pkg::OFFSET_W;
   localparam int PAT_WORD_W = wbss_pkg::PAT_WORD_W;
   localparam int PAT_WORDS  = wbss_pkg::PAT_WORDS;
   localparam int CSR_IDX_W  = wbss_pkg::CSR_IDX_W;
   localparam int CSR_DATA_W = wbss_pkg::CSR_DATA_W;

   localparam int              MAX_PAT       = wbss_pkg::MAX_PATTERN_DEF;
   localparam int              POS_BITS      = wbss_pkg::POSITION_BITS_DEF;
   localparam longint unsigned POS_TOP       = (64'd1 << POS_BITS) - 64'd1;
   localparam int              SETTLE_CYCLES = 8;
   localparam int              CYCLE_LIMIT   = 600000;
   localparam int              LONG_HOLD     = 220;
   localparam int              REPORT_MAX    = 10;

   // register indexes that the block does not decode
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_6 = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_7 = 3'd7;

   typedef struct packed {
      logic                found;
      logic [OFFSET_W-1:0] offset;
      logic                sole;
   } verdict_type;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  csr_write_en;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_write_data;

   wbss_req_if req_bus ();
   wbss_rsp_if rsp_bus ();

   wildcard_byte_signature_scanner dut (
      .clock          (clock),
      .reset          (reset),
      .req_bus        (req_bus),
      .rsp_bus        (rsp_bus),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data)
   );

   always #10 clock = ~clock;

   // register shadow
   logic [PAT_WORD_W-1:0] pat_word [PAT_WORDS];
   logic [MASK_W-1:0]     wild_mask;
   logic [LEN_W-1:0]      pat_len;

   // scan shadow
   logic [DATA_W-1:0] scan_window [MAX_PAT];
   int unsigned       range_fill;
   longint unsigned   scan_pos;
   logic              first_hit;
   longint unsigned   first_hit_at;
   logic              second_hit;
   verdict_type       predicted_verdicts [$];

   // traffic shaping
   bit req_gaps_on     = 1'b1;
   bit rsp_stalls_on   = 1'b1;
   int rsp_hold_cycles = 0;

   // tallies
   int requests_sent      = 0;
   int verdicts_checked   = 0;
   int verdicts_found     = 0;
   int verdicts_ambiguous = 0;
   int settings_used      = 0;
   int mismatch_count     = 0;
   int cycle_count        = 0;

   function automatic logic [DATA_W-1:0] pattern_byte(input int j);
      return pat_word[j / 8][(j % 8) * DATA_W +: DATA_W];
   endfunction

   function automatic void clear_scan_shadow();
      foreach (scan_window[i]) scan_window[i] = '0;
      range_fill   = 0;
      scan_pos     = 0;
      first_hit    = 1'b0;
      first_hit_at = 0;
      second_hit   = 1'b0;
   endfunction

   // shift one byte into the window, run the masked compare, close the scan
   function automatic void track_scan_byte(input logic [DATA_W-1:0] value,
                                           input logic first_of_range,
                                           input logic end_of_scan);
      int              k;
      bit              hit;
      longint unsigned back;
      longint unsigned at;
      verdict_type     v;
      if (first_of_range) begin
         foreach (scan_window[i]) scan_window[i] = '0;
         range_fill = 0;
      end
      for (k = MAX_PAT - 1; k > 0; k--) scan_window[k] = scan_window[k - 1];
      scan_window[0] = value;
      if (range_fill < MAX_PAT) range_fill++;

      hit = (pat_len != 0) && (int'(pat_len) <= MAX_PAT) && (range_fill >= pat_len);
      if (hit) begin
         // pattern byte k sits len-1-k places behind the newest byte
         for (k = 0; k < int'(pat_len); k++)
            if (!wild_mask[k] && scan_window[int'(pat_len) - 1 - k] !== pattern_byte(k))
               hit = 1'b0;
      end
      if (hit) begin
         back = longint'(pat_len) - 1;
         at   = (scan_pos >= back) ? scan_pos - back : 0;
         if (!first_hit) begin
            first_hit    = 1'b1;
            first_hit_at = at;
         end else begin
            second_hit = 1'b1;
         end
      end
      if (scan_pos < POS_TOP) scan_pos++;

      if (end_of_scan) begin
         v.found  = first_hit;
         v.offset = first_hit ? first_hit_at[OFFSET_W-1:0] : '0;
         v.sole   = !second_hit;
         predicted_verdicts = {predicted_verdicts, v};
         clear_scan_shadow();
      end
   endfunction

   // one register write; the caller lowers the write enable after a burst
   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] value);
      csr_write_en   <= 1'b1;
      csr_index      <= idx;
      csr_write_data <= value;
      @(posedge clock);
      case (idx)
         wbss_pkg::CSR_PATTERN_0, wbss_pkg::CSR_PATTERN_1,
         wbss_pkg::CSR_PATTERN_2, wbss_pkg::CSR_PATTERN_3: begin
            pat_word[idx[1:0]] = value;
         end
         wbss_pkg::CSR_WILDCARD: begin
            wild_mask = value[MASK_W-1:0];
         end
         wbss_pkg::CSR_LENGTH: begin
            pat_len = value[LEN_W-1:0];
         end
         default: begin
            // undecoded index, nothing changes
         end
      endcase
   endtask

   // stop sending and wait until the block has nothing left in flight
   task automatic settle_block();
      req_bus.valid <= 1'b0;
      while (predicted_verdicts.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic apply_setting(input logic [PAT_WORDS*PAT_WORD_W-1:0] words,
                                input logic [CSR_DATA_W-1:0] mask_word,
                                input logic [CSR_DATA_W-1:0] len_word,
                                input bit poke_spare);
      settle_block();
      write_csr(wbss_pkg::CSR_PATTERN_0, words[0*PAT_WORD_W +: PAT_WORD_W]);
      write_csr(wbss_pkg::CSR_PATTERN_1, words[1*PAT_WORD_W +: PAT_WORD_W]);
      write_csr(wbss_pkg::CSR_PATTERN_2, words[2*PAT_WORD_W +: PAT_WORD_W]);
      write_csr(wbss_pkg::CSR_PATTERN_3, words[3*PAT_WORD_W +: PAT_WORD_W]);
      write_csr(wbss_pkg::CSR_WILDCARD, mask_word);
      write_csr(wbss_pkg::CSR_LENGTH, len_word);
      if (poke_spare) begin
         write_csr(CSR_SPARE_6, '1);
         write_csr(CSR_SPARE_7, '1);
      end
      csr_write_en <= 1'b0;
      settings_used++;
   endtask

   // random pattern contents for a given length; upper write bits are junk
   task automatic pick_random_setting(input int len);
      logic [PAT_WORDS*PAT_WORD_W-1:0] words;
      logic [CSR_DATA_W-1:0]           mask_word;
      logic [CSR_DATA_W-1:0]           len_word;
      logic [DATA_W-1:0]               fill;
      int                              j;
      for (j = 0; j < PAT_WORDS * 2; j++) words[j*32 +: 32] = $urandom;
      case ($urandom_range(0, 7))
         0: words = '1;
         1: words = '0;
         2: begin
            // one repeated byte gives plenty of overlapping hits
            fill  = $urandom_range(0, 255);
            words = {(PAT_WORDS * PAT_WORD_W / DATA_W){fill}};
         end
         default: ;
      endcase
      mask_word = {$urandom, $urandom};
      case ($urandom_range(0, 5))
         0, 1: mask_word[MASK_W-1:0] = '0;
         2, 3: mask_word[MASK_W-1:0] = $urandom & $urandom & $urandom;
         4:    mask_word[MASK_W-1:0] = $urandom;
         default: mask_word[MASK_W-1:0] = '1;
      endcase
      len_word = {$urandom, $urandom};
      len_word[LEN_W-1:0] = LEN_W'(len);
      apply_setting(words, mask_word, len_word, 1'b0);
   endtask

   task automatic send_request(input logic [DATA_W-1:0] value,
                               input logic first_of_range,
                               input logic end_of_scan);
      if (req_gaps_on && $urandom_range(0, 5) == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 13)) @(posedge clock);
      end
      req_bus.valid       <= 1'b1;
      req_bus.data_byte   <= value;
      req_bus.range_start <= first_of_range;
      req_bus.scan_end    <= end_of_scan;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      track_scan_byte(value, first_of_range, end_of_scan);
      requests_sent++;
   endtask

   // one scan: random bytes with planted pattern copies, some of them broken
   task automatic send_random_scan(input int max_len, output int n_sent);
      logic [DATA_W-1:0] bytes_q [$];
      logic              starts_q [$];
      logic [DATA_W-1:0] b;
      int                target;
      int                span;
      int                j;
      int                k;
      target = ($urandom_range(0, 11) == 0) ? $urandom_range(max_len, 3 * max_len)
                                            : $urandom_range(1, max_len);
      span = (pat_len == 0) ? 4 : ((int'(pat_len) > MAX_PAT) ? MAX_PAT : int'(pat_len));
      while (bytes_q.size() < target) begin
         k = $urandom_range(0, 9);
         if (k < 4) begin
            for (j = 0; j < span; j++) begin
               b = wild_mask[j] ? DATA_W'($urandom_range(0, 255)) : pattern_byte(j);
               bytes_q  = {bytes_q, b};
               starts_q = {starts_q, 1'b0};
            end
            if (k == 3) begin
               // corrupt one bit of the copy
               j = bytes_q.size() - 1 - $urandom_range(0, span - 1);
               bytes_q[j] = bytes_q[j] ^ (8'd1 << $urandom_range(0, 7));
            end
         end else begin
            b = ($urandom_range(0, 1) == 0) ? DATA_W'($urandom)
                                            : pattern_byte($urandom_range(0, MAX_PAT - 1));
            bytes_q  = {bytes_q, b};
            starts_q = {starts_q, ($urandom_range(0, 15) == 0)};
         end
      end
      starts_q[0] = ($urandom_range(0, 3) != 0);
      // now and then a range boundary lands inside a planted copy
      if ($urandom_range(0, 4) == 0) starts_q[$urandom_range(0, bytes_q.size() - 1)] = 1'b1;
      for (j = 0; j < bytes_q.size(); j++)
         send_request(bytes_q[j], starts_q[j], j == bytes_q.size() - 1);
      n_sent = bytes_q.size();
   endtask

   task automatic run_random_phase(input int n_items, input int max_len);
      int sent;
      int n;
      sent = 0;
      while (sent < n_items) begin
         send_random_scan(max_len, n);
         sent += n;
      end
   endtask

   // ---------------------------------------------------------------- tests

   // registers at reset: length zero, nothing may match
   task automatic test_empty_pattern();
      send_request(8'h00, 1'b0, 1'b0);
      send_request(8'hFF, 1'b0, 1'b0);
      send_request(8'h00, 1'b0, 1'b1);
   endtask

   // DE AD ?? EF: hit through the wildcard, then a copy cut by a range start
   task automatic test_wildcard_and_range_break();
      apply_setting({192'd0, 64'h0000_0000_EF00_ADDE}, 64'h4, 64'd4, 1'b0);
      send_request(8'h11, 1'b1, 1'b0);
      send_request(8'hDE, 1'b0, 1'b0);
      send_request(8'hAD, 1'b0, 1'b0);
      send_request(8'h77, 1'b0, 1'b0);
      send_request(8'hEF, 1'b0, 1'b0);
      send_request(8'hDE, 1'b0, 1'b0);
      send_request(8'hAD, 1'b0, 1'b0);
      send_request(8'h99, 1'b1, 1'b0);
      send_request(8'hEF, 1'b0, 1'b1);
   endtask

   // AA AA over three AA bytes: two overlapping hits, verdict is ambiguous
   task automatic test_overlapping_hits();
      apply_setting({192'd0, 64'hAAAA}, 64'd0, 64'd2, 1'b0);
      send_request(8'hAA, 1'b1, 1'b0);
      send_request(8'hAA, 1'b0, 1'b0);
      send_request(8'hAA, 1'b0, 1'b1);
   endtask

   // single-byte scans, mostly with range start and scan end on the same request
   task automatic test_byte_extremes();
      apply_setting({192'd0, 64'hFF}, 64'd0, 64'd1, 1'b0);
      send_request(8'hFF, 1'b1, 1'b1);
      send_request(8'h00, 1'b0, 1'b1);
      apply_setting({192'd0, 64'hFF}, 64'd1, 64'd1, 1'b0);
      send_request(8'h00, 1'b1, 1'b1);
   endtask

   // writes to undecoded indexes change nothing; length above the window never hits
   task automatic test_spare_index_and_overlong();
      apply_setting({192'd0, 64'h5A}, 64'd0, 64'd1, 1'b1);
      send_request(8'h5A, 1'b1, 1'b1);
      apply_setting('1, '1, 64'd40, 1'b0);
      send_request(8'h00, 1'b1, 1'b0);
      send_request(8'hFF, 1'b0, 1'b1);
   endtask

   task automatic test_random_settings();
      int lengths [14] = '{1, 2, 3, 4, 6, 8, 12, 16, 24, 31, 32, 0, 40, 63};
      int max_len;
      foreach (lengths[i]) begin
         pick_random_setting(lengths[i]);
         max_len = (lengths[i] == 0) ? 12 : ((lengths[i] > 20) ? 40 : 2 * lengths[i] + 6);
         run_random_phase(86, max_len);
      end
   endtask

   // long response hold while short scans keep coming, then a full drain
   task automatic test_response_hold();
      pick_random_setting(2);
      req_gaps_on     = 1'b0;
      rsp_hold_cycles = LONG_HOLD;
      run_random_phase(90, 2);
      settle_block();
      run_random_phase(30, 2);
      req_gaps_on = 1'b1;
   endtask

   // closing stretch at full rate on both sides
   task automatic test_back_to_back();
      pick_random_setting(5);
      req_gaps_on   = 1'b0;
      rsp_stalls_on = 1'b0;
      run_random_phase(100, 10);
   endtask

   // response side: random ready bursts, plus a long hold on request
   initial begin : verdict_receiver
      int   burst;
      logic level;
      rsp_bus.ready = 1'b0;
      @(posedge clock);
      forever begin
         if (rsp_hold_cycles > 0) begin
            burst           = rsp_hold_cycles;
            rsp_hold_cycles = 0;
            level           = 1'b0;
         end else if (rsp_stalls_on && $urandom_range(0, 3) == 0) begin
            burst = $urandom_range(1, 13);
            level = 1'b0;
         end else begin
            burst = rsp_stalls_on ? $urandom_range(1, 13) : 1;
            level = 1'b1;
         end
         rsp_bus.ready <= level;
         repeat (burst) @(posedge clock);
      end
   end

   // compare each accepted response with the oldest predicted verdict
   always @(posedge clock) begin : verdict_checker
      verdict_type seen;
      verdict_type want;
      if (reset === 1'b0 && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         seen.found  = rsp_bus.found;
         seen.offset = rsp_bus.match_offset;
         seen.sole   = rsp_bus.unique_res;
         if (predicted_verdicts.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_MAX)
               $display("[%0t] response with none awaited: found=%b offset=%0d unique=%b",
                        $realtime, seen.found, seen.offset, seen.sole);
         end else begin
            want = predicted_verdicts.pop_front();
            verdicts_checked++;
            if (want.found) verdicts_found++;
            if (!want.sole) verdicts_ambiguous++;
            if (seen.found !== want.found || seen.offset !== want.offset ||
                seen.sole !== want.sole) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_MAX)
                  $display("[%0t] verdict %0d: expected found=%b offset=%0d unique=%b, %s",
                           $realtime, verdicts_checked, want.found, want.offset, want.sole,
                           $sformatf("got found=%b offset=%0d unique=%b",
                                     seen.found, seen.offset, seen.sole));
            end
         end
      end
   end

   // run limit
   initial begin : run_limit
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("tb: run limit of %0d cycles reached", CYCLE_LIMIT);
      $display("** wildcard_byte_signature_scanner: FAILED **");
      $finish;
   end

   // test sequence
   initial begin : main_sequence
      reset               = 1'b1;
      csr_write_en        = 1'b0;
      csr_index           = '0;
      csr_write_data      = '0;
      req_bus.valid       = 1'b0;
      req_bus.data_byte   = '0;
      req_bus.range_start = 1'b0;
      req_bus.scan_end    = 1'b0;
      foreach (pat_word[i]) pat_word[i] = '0;
      wild_mask = '0;
      pat_len   = '0;
      clear_scan_shadow();
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      test_empty_pattern();
      test_wildcard_and_range_break();
      test_overlapping_hits();
      test_byte_extremes();
      test_spare_index_and_overlong();
      test_random_settings();
      test_response_hold();
      test_back_to_back();
      settle_block();

      $display("tb: %0d requests over %0d register settings, %0d verdicts checked",
               requests_sent, settings_used, verdicts_checked);
      $display("tb: %0d verdicts with a hit, %0d ambiguous, %0d mismatches",
               verdicts_found, verdicts_ambiguous, mismatch_count);
      if (mismatch_count == 0 && predicted_verdicts.size() == 0) begin
         $display("** wildcard_byte_signature_scanner: PASSED **");
      end else begin
         $display("** wildcard_byte_signature_scanner: FAILED **");
      end
      $finish;
   end

endmodule

@@ sim.f @@
rtl/core/wbss_pkg.sv
rtl/core/wbss_channels.sv
rtl/core/wildcard_byte_signature_scanner.sv
rtl/core/wbss_checker.sv
bench/tb.sv
